[hw/rtl/klsb_pkg.sv]
// Shared constants and types for the k lowest score buffer.
`timescale 1ns / 1ps

package klsb_pkg;

   parameter int unsigned BUFFER_DEPTH = 32;
   parameter int unsigned IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   parameter int unsigned CNT_W = $clog2(BUFFER_DEPTH + 1);

   parameter int unsigned SCORE_W = 32;
   parameter int unsigned ID_W = 31;
   parameter int unsigned FILL_W = 6;
   parameter int unsigned ENTRY_W = SCORE_W + ID_W;

   parameter int unsigned REQ_TDATA_W = ((SCORE_W + ID_W + 7) / 8) * 8;
   parameter int unsigned RSP_TDATA_W = ((ID_W + FILL_W + 1 + 7) / 8) * 8;

   parameter logic MODE_ADD = 1'b0;
   parameter logic MODE_CLEAR = 1'b1;

   typedef struct packed {
      logic clear;
      logic sample;
   } cmp_ctl_type;

   typedef struct packed {
      logic [ID_W-1:0]    min_id;
      logic [SCORE_W-1:0] run_max;
      logic               eq_max;
   } cmp_sts_type;

endpackage

[hw/rtl/klsb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module klsb_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/klsb_cmp.sv]
// Shared compare unit: running minimum, running maximum and max-match test.
`timescale 1ns / 1ps

module klsb_cmp (
   input  logic                          clock,
   input  logic                          reset,
   input  klsb_pkg::cmp_ctl_type         ctl,
   input  logic [klsb_pkg::SCORE_W-1:0]  rd_score,
   input  logic [klsb_pkg::ID_W-1:0]     rd_id,
   input  logic [klsb_pkg::SCORE_W-1:0]  max_ref,
   output klsb_pkg::cmp_sts_type         sts
);

   logic                         first_ff, first_in;
   logic [klsb_pkg::SCORE_W-1:0] min_score_ff, min_score_in;
   logic [klsb_pkg::ID_W-1:0]    min_id_ff, min_id_in;
   logic [klsb_pkg::SCORE_W-1:0] run_max_ff, run_max_in;

   always_comb begin
      first_in = first_ff;
      min_score_in = min_score_ff;
      min_id_in = min_id_ff;
      run_max_in = run_max_ff;
      if (ctl.clear) begin
         first_in = 1'b1;
         run_max_in = '0;
      end else if (ctl.sample) begin
         // strict less keeps the lowest index on ties
         if (first_ff || (rd_score < min_score_ff)) begin
            min_score_in = rd_score;
            min_id_in = rd_id;
         end
         if (rd_score > run_max_ff) begin
            run_max_in = rd_score;
         end
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         run_max_ff <= '0;
      end else begin
         first_ff <= first_in;
         run_max_ff <= run_max_in;
      end
   end

   always_ff @(posedge clock) begin
      min_score_ff <= min_score_in;
      min_id_ff <= min_id_in;
   end

   assign sts.min_id = min_id_ff;
   assign sts.run_max = run_max_ff;
   assign sts.eq_max = (rd_score == max_ref);

endmodule

[hw/rtl/k_lowest_score_buffer.sv]
// Top level of the k lowest score buffer: sequencer, entry RAM, compare unit.
//
//  Channel | Dir | Handshake           | tdata (low bit up)              | tuser
//  req     | in  | req_tvalid/tready   | score[31:0], cluster_id[62:32]  | mode
//  rsp     | out | rsp_tvalid/tready   | best_id, fill_count, kept       | best_valid
//
// Clear goes straight to the result. Append: one min scan over held entries.
// Replace: max search, then min/max rescan; an item not kept on a full buffer gets the min scan only.
// Each scan is paced by the single RAM read port, one entry per cycle.
// Reset empties the buffer; RAM contents are left as they are.
// A result waiting on rsp_tready does not block the next req item.
`timescale 1ns / 1ps

module k_lowest_score_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // score[31:0], cluster_id[62:32], zero pad
   input  logic [klsb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode[0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // best_id[30:0], fill_count[36:31], kept[37], zero pad
   output logic [klsb_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // best_valid[0]
   output logic                                rsp_tuser
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FIND = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int unsigned SW = klsb_pkg::SCORE_W;
   localparam int unsigned IW = klsb_pkg::ID_W;
   localparam int unsigned XW = klsb_pkg::IDX_W;
   localparam int unsigned CW = klsb_pkg::CNT_W;
   localparam int unsigned FW = klsb_pkg::FILL_W;
   localparam int unsigned PAD_W = klsb_pkg::RSP_TDATA_W - IW - FW - 1;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] max_ff, max_in;
   logic [SW-1:0] score_ff, score_in;
   logic [IW-1:0] id_ff, id_in;
   logic          kept_ff, kept_in;
   logic          repl_ff, repl_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [XW-1:0] pend_idx_ff, pend_idx_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [klsb_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   logic                             accept;
   logic [SW-1:0]                    req_score;
   logic [IW-1:0]                    req_id;
   logic                             wr_en;
   logic [XW-1:0]                    wr_addr;
   logic [klsb_pkg::ENTRY_W-1:0]     wr_data;
   logic                             rd_en;
   logic [klsb_pkg::ENTRY_W-1:0]     rd_data;
   logic                             scan_end;
   logic                             full;
   klsb_pkg::cmp_ctl_type            cmp_ctl;
   klsb_pkg::cmp_sts_type            cmp_sts;

   assign req_score = req_tdata[SW-1:0];
   assign req_id = req_tdata[SW+IW-1:SW];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign full = (count_ff == CW'(klsb_pkg::BUFFER_DEPTH));
   assign rd_en = ((state_ff == ST_FIND) || (state_ff == ST_SCAN)) && (idx_ff < count_ff);
   assign scan_end = (idx_ff == count_ff) && !pend_ff;

   assign cmp_ctl.clear = (state_ff == ST_IDLE) || (state_ff == ST_FIND);
   assign cmp_ctl.sample = (state_ff == ST_SCAN) && pend_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      max_in = max_ff;
      score_in = score_ff;
      id_in = id_ff;
      kept_in = kept_ff;
      repl_in = repl_ff;
      idx_in = rd_en ? idx_ff + CW'(1) : idx_ff;
      pend_in = rd_en;
      pend_idx_in = idx_ff[XW-1:0];
      wr_en = 1'b0;
      wr_addr = count_ff[XW-1:0];
      wr_data = {req_id, req_score};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            pend_in = 1'b0;
            if (accept) begin
               score_in = req_score;
               id_in = req_id;
               kept_in = 1'b0;
               repl_in = 1'b0;
               if (req_tuser == klsb_pkg::MODE_CLEAR) begin
                  count_in = '0;
                  max_in = '0;
                  state_in = ST_DONE;
               end else if (!full) begin
                  wr_en = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (req_score > max_ff) begin
                     max_in = req_score;
                  end
                  kept_in = 1'b1;
                  state_in = ST_SCAN;
               end else if (req_score < max_ff) begin
                  state_in = ST_FIND;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FIND: begin
            if (pend_ff && cmp_sts.eq_max) begin
               wr_en = 1'b1;
               wr_addr = pend_idx_ff;
               wr_data = {id_ff, score_ff};
               kept_in = 1'b1;
               repl_in = 1'b1;
               idx_in = '0;
               pend_in = 1'b0;
               state_in = ST_SCAN;
            end else if (scan_end) begin
               idx_in = '0;
               pend_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               if (repl_ff) begin
                  max_in = cmp_sts.run_max;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = (count_ff != '0);
               rsp_data_in = {PAD_W'(0), kept_ff, FW'(count_ff),
                              (count_ff != '0) ? cmp_sts.min_id : IW'(0)};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         max_ff <= '0;
         kept_ff <= 1'b0;
         repl_ff <= 1'b0;
         idx_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         max_ff <= max_in;
         kept_ff <= kept_in;
         repl_ff <= repl_in;
         idx_ff <= idx_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff <= score_in;
      id_ff <= id_in;
      pend_idx_ff <= pend_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   klsb_ram #(
      .WIDTH(klsb_pkg::ENTRY_W),
      .DEPTH(klsb_pkg::BUFFER_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(idx_ff[XW-1:0]),
      .rd_data(rd_data)
   );

   klsb_cmp u_cmp (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cmp_ctl),
      .rd_score(rd_data[SW-1:0]),
      .rd_id   (rd_data[SW+IW-1:SW]),
      .max_ref (max_ff),
      .sts     (cmp_sts)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

[hw/rtl/klsb_checker.sv]
// Port-level checks for the k lowest score buffer, bound to the top level.
`timescale 1ns / 1ps

module klsb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [klsb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   localparam int unsigned IW = klsb_pkg::ID_W;
   localparam int unsigned FW = klsb_pkg::FILL_W;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_valid_matches_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[IW+FW-1:IW] != '0)))
      else $error("best_valid disagrees with fill_count");

   a_kept_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[IW+FW] |-> rsp_tuser)
      else $error("kept item but buffer reported empty");

   a_empty_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[IW-1:0] == '0))
      else $error("empty buffer reported nonzero best_id");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind k_lowest_score_buffer klsb_checker u_klsb_checker (.*);

[tb/klsb_result_checker.sv]
// Checker for the k lowest score buffer: predicts each result and compares it.
`timescale 1ns / 1ps

module klsb_result_checker
   import klsb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   output int unsigned            error_count,
   output int unsigned            pending_count
);

   typedef struct packed {
      logic [ID_W-1:0]   best_id;
      logic              best_valid;
      logic [FILL_W-1:0] fill_count;
      logic              kept;
   } outcome_type;

   logic [SCORE_W-1:0] score_mem [BUFFER_DEPTH];
   logic [ID_W-1:0]    id_mem [BUFFER_DEPTH];
   int unsigned        held = 0;
   logic [SCORE_W-1:0] top_score = '0;
   outcome_type        awaited_results [$];
   int unsigned        errors = 0;
   int unsigned        waiting = 0;

   assign error_count = errors;
   assign pending_count = waiting;

   function automatic outcome_type next_outcome(logic mode, logic [SCORE_W-1:0] score,
                                                logic [ID_W-1:0] id);
      outcome_type        o;
      logic [SCORE_W-1:0] low;
      o = '0;
      if (mode == MODE_CLEAR) begin
         held = 0;
         top_score = '0;
      end else if (held < BUFFER_DEPTH) begin
         score_mem[held] = score;
         id_mem[held] = id;
         held++;
         if (score > top_score)
            top_score = score;
         o.kept = 1'b1;
      end else if (score < top_score) begin
         // overwrite the first entry holding the maximum, then rescan
         for (int i = 0; i < BUFFER_DEPTH; i++) begin
            if (!o.kept && score_mem[i] == top_score) begin
               score_mem[i] = score;
               id_mem[i] = id;
               o.kept = 1'b1;
            end
         end
         if (o.kept) begin
            top_score = '0;
            for (int i = 0; i < BUFFER_DEPTH; i++)
               if (score_mem[i] > top_score)
                  top_score = score_mem[i];
         end
      end
      if (held > 0) begin
         low = score_mem[0];
         o.best_id = id_mem[0];
         o.best_valid = 1'b1;
         for (int i = 1; i < held; i++) begin
            if (score_mem[i] < low) begin
               low = score_mem[i];
               o.best_id = id_mem[i];
            end
         end
      end
      o.fill_count = FILL_W'(held);
      return o;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      outcome_type seen;
      outcome_type want;
      if (reset) begin
         held = 0;
         top_score = '0;
         awaited_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            awaited_results.push_back(next_outcome(req_tuser, req_tdata[SCORE_W-1:0],
                                                   req_tdata[SCORE_W +: ID_W]));
         if (rsp_tvalid && rsp_tready) begin
            seen.best_id = rsp_tdata[ID_W-1:0];
            seen.fill_count = rsp_tdata[ID_W +: FILL_W];
            seen.kept = rsp_tdata[ID_W + FILL_W];
            seen.best_valid = rsp_tuser;
            if (awaited_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, expected none actual 0x%0h", $time, seen);
            end else begin
               want = awaited_results.pop_front();
               check_field("best_id", 32'(want.best_id), 32'(seen.best_id));
               check_field("best_valid", 32'(want.best_valid), 32'(seen.best_valid));
               check_field("fill_count", 32'(want.fill_count), 32'(seen.fill_count));
               check_field("kept", 32'(want.kept), 32'(seen.kept));
            end
         end
      end
      waiting <= awaited_results.size();
   end

endmodule

[tb/testbench.sv]
// Top of the k lowest score buffer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import klsb_pkg::*;

   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES = 2 * BUFFER_DEPTH + 16;
   localparam int unsigned RANDOM_ITEMS = 1630;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = MODE_ADD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned quiet_cycles = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned items_sent = 0;

   k_lowest_score_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   klsb_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (mismatches),
      .pending_count (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("k_lowest_score_buffer verification failed");
      $finish;
   end

   function automatic bit chance(int unsigned pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   function automatic void set_idling(int unsigned phase);
      case (phase)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 63; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 63; end
         default: begin idle_pct = 36; stall_pct = 36; end
      endcase
   endfunction

   // flavors: full range, tiny range (ties), extremes, whole Q16.16 values
   function automatic logic [SCORE_W-1:0] pick_score(int unsigned flavor);
      case (flavor)
         0: return $urandom;
         1: return $urandom_range(15, 0);
         2: begin
            case ($urandom_range(3, 0))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hFFFF_FFFE;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return SCORE_W'($urandom_range(40, 0)) << 16;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      if (chance(5))
         return chance(50) ? {ID_W{1'b1}} : '0;
      return ID_W'($urandom);
   endfunction

   task automatic push_item(logic mode, logic [SCORE_W-1:0] score, logic [ID_W-1:0] id);
      while (chance(idle_pct)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {{(REQ_TDATA_W - SCORE_W - ID_W){1'b0}}, id, score};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // wait for the next clock edge first so the count includes the item just accepted
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   initial begin
      int unsigned flavor;
      int unsigned run;
      bit          paused;
      paused = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_idling(0);
      push_item(MODE_CLEAR, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      push_item(MODE_ADD, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
      push_item(MODE_ADD, 32'h0000_0000, 31'h0000_0000);
      push_item(MODE_ADD, 32'h0000_0000, 31'h0000_0005);
      push_item(MODE_ADD, 32'h0001_8000, 31'h2AAA_AAAA);
      push_item(MODE_ADD, 32'h8000_0000, 31'h5555_5555);
      push_item(MODE_ADD, 32'hFFFF_FFFF, 31'h0000_0009);
      push_item(MODE_CLEAR, 32'h0000_0000, 31'h0000_0000);
      push_item(MODE_ADD, 32'h0001_0000, 31'h0000_0001);
      push_item(MODE_ADD, 32'h0000_FFFF, 31'h0000_0002);
      push_item(MODE_CLEAR, 32'h5555_5555, 31'h2AAA_AAAA);
      push_item(MODE_CLEAR, 32'hAAAA_AAAA, 31'h5555_5555);
      push_item(MODE_ADD, 32'h0000_0001, 31'h7FFF_FFFE);
      settle();

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         set_idling((items_sent * 8 / RANDOM_ITEMS) % 4);
         if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
            settle();
            paused = 1'b1;
         end
         flavor = $urandom_range(3, 0);
         if (chance(70))
            push_item(MODE_CLEAR, $urandom, ID_W'($urandom));
         run = chance(80) ? $urandom_range(BUFFER_DEPTH + 48, BUFFER_DEPTH)
                          : $urandom_range(BUFFER_DEPTH, 1);
         repeat (run)
            push_item(chance(3) ? MODE_CLEAR : MODE_ADD, pick_score(flavor), pick_id());
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("k_lowest_score_buffer verification clean");
      else
         $display("k_lowest_score_buffer verification failed");
      $finish;
   end

endmodule
